FILE: design/convolution_reverb_wet_dry_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the convolution reverb block
// Shared property templates used by the port checker.
// ---------------------------------------------------------------------------
`ifndef CONVOLUTION_REVERB_WET_DRY_TOP_DEFINES_SVH
`define CONVOLUTION_REVERB_WET_DRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cvr_pkg.sv
// ---------------------------------------------------------------------------
// Convolution reverb package
// Field widths, mix constants and the structs passed between the modules.
// ---------------------------------------------------------------------------
package cvr_pkg;

    // Item field widths
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned TAP_IDX_W = 10;
    localparam int unsigned CH_W      = 1;
    localparam int unsigned CH_IDS    = 2 ** CH_W;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned PROD_W    = 2 * SAMPLE_W;

    // Stream packing
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // Item kinds carried on the input tuser
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Mix scaling: taps are Q1.15, wet share in percent
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam int unsigned      FRAC_BITS = SAMPLE_W - 1;

    // Magnitude clamp ahead of the divide by 100: anything at or above this
    // saturates for either sign, so the divider only sees 22-bit values
    localparam int unsigned         CLAMP_W   = 22;
    localparam logic [CLAMP_W-1:0]  MAG_CLAMP =
        CLAMP_W'(100 * (2 ** (SAMPLE_W - 1) + 1));

    // Reciprocal of 100 for a 22-bit dividend: ceil(2^29 / 100)
    localparam int unsigned         RECIP_SHIFT = 29;
    localparam int unsigned         RECIP_W     = 23;
    localparam logic [RECIP_W-1:0]  RECIP_100   = 23'd5368710;

    // Saturation limits as magnitudes
    localparam logic [SAMPLE_W-1:0] MAG_POS_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [SAMPLE_W-1:0] MAG_NEG_MAX = SAMPLE_W'(2 ** (SAMPLE_W - 1));

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic issue;
    } t_mac_ctl;

    // Mixed and saturated result
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
    } t_mix_res;

endpackage

FILE: design/cvr_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module cvr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/cvr_mac.sv
// ---------------------------------------------------------------------------
// Convolution multiply-accumulate unit
// Multiplies one tap by one history sample per cycle and sums the products.
// ---------------------------------------------------------------------------
module cvr_mac #(
    parameter int unsigned ACC_W = 42
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cvr_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [cvr_pkg::SAMPLE_W-1:0]  i_tap,
    input  logic signed [cvr_pkg::SAMPLE_W-1:0]  i_hist,
    output logic signed [ACC_W-1:0]              o_acc,
    output logic                                 o_empty
);

    logic                                r_dv;
    logic                                r_pv;
    logic signed [cvr_pkg::PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]             r_acc;

    // Track read data and product validity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_dv <= i_ctl.issue;
            r_pv <= r_dv;
        end
    end

    // Register the product of the memory outputs
    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_prod <= i_tap * i_hist;
        end
    end

    // Clear at the start of a sample, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc   = r_acc;
    assign o_empty = !r_dv && !r_pv;

endmodule

FILE: design/cvr_mix.sv
// ---------------------------------------------------------------------------
// Wet/dry mixer
// Forms conv*wet + dry*2^15*(100-wet), divides by 100*2^15 toward zero and
// saturates to 16 bits over a five-stage pipeline.
// ---------------------------------------------------------------------------
module cvr_mix #(
    parameter int unsigned ACC_W = 42
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ACC_W-1:0]              i_acc,
    input  logic signed [cvr_pkg::SAMPLE_W-1:0]  i_dry,
    input  logic [cvr_pkg::PCT_W-1:0]            i_wet,
    output logic                                 o_done,
    output cvr_pkg::t_mix_res                    o_res
);

    localparam int unsigned WET_PROD_W = ACC_W + cvr_pkg::PCT_W + 1;
    localparam int unsigned DRY_PROD_W = cvr_pkg::SAMPLE_W + cvr_pkg::PCT_W + 1;
    localparam int unsigned MIX_W      = WET_PROD_W + 1;
    localparam int unsigned QPROD_W    = cvr_pkg::CLAMP_W + cvr_pkg::RECIP_W;

    logic [4:0]                         r_v;
    logic [cvr_pkg::PCT_W-1:0]          w_wet_eff;
    logic [cvr_pkg::PCT_W-1:0]          w_dry_pct;
    logic signed [WET_PROD_W-1:0]       r_wet_prod;
    logic signed [DRY_PROD_W-1:0]       r_dry_prod;
    logic signed [MIX_W-1:0]            r_mix;
    logic [MIX_W-1:0]                   w_mag;
    logic [MIX_W-1:0]                   w_shr;
    logic [cvr_pkg::CLAMP_W-1:0]        w_mag_cl;
    logic [cvr_pkg::CLAMP_W-1:0]        r_mag;
    logic                               r_neg3;
    logic [QPROD_W-1:0]                 w_qprod;
    logic [cvr_pkg::SAMPLE_W-1:0]       r_quo;
    logic                               r_neg4;
    logic [cvr_pkg::SAMPLE_W-1:0]       w_quo_neg;
    cvr_pkg::t_mix_res                  w_res;
    cvr_pkg::t_mix_res                  r_res;

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_start};
        end
    end

    // Clamp the wet share to 100 percent
    assign w_wet_eff = (i_wet > cvr_pkg::PCT_FULL) ? cvr_pkg::PCT_FULL : i_wet;
    assign w_dry_pct = cvr_pkg::PCT_FULL - w_wet_eff;

    // Stage 1: weight the wet and dry paths
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wet_prod <= i_acc * $signed({1'b0, w_wet_eff});
            r_dry_prod <= i_dry * $signed({1'b0, w_dry_pct});
        end
    end

    // Stage 2: sum with the dry path lifted to Q15
    always_ff @(posedge i_clk) begin
        if (r_v[0]) begin
            r_mix <= MIX_W'(r_wet_prod) + (MIX_W'(r_dry_prod) <<< cvr_pkg::FRAC_BITS);
        end
    end

    // Stage 3: magnitude, drop the fraction, clamp far overflows
    assign w_mag    = r_mix[MIX_W-1] ? MIX_W'(-r_mix) : MIX_W'(r_mix);
    assign w_shr    = w_mag >> cvr_pkg::FRAC_BITS;
    assign w_mag_cl = (w_shr >= MIX_W'(cvr_pkg::MAG_CLAMP)) ? cvr_pkg::MAG_CLAMP
                                                             : cvr_pkg::CLAMP_W'(w_shr);

    always_ff @(posedge i_clk) begin
        if (r_v[1]) begin
            r_mag  <= w_mag_cl;
            r_neg3 <= r_mix[MIX_W-1];
        end
    end

    // Stage 4: divide the magnitude by 100 through its reciprocal
    assign w_qprod = QPROD_W'(r_mag) * QPROD_W'(cvr_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (r_v[2]) begin
            r_quo  <= w_qprod[cvr_pkg::RECIP_SHIFT +: cvr_pkg::SAMPLE_W];
            r_neg4 <= r_neg3;
        end
    end

    // Stage 5: restore the sign and saturate
    assign w_quo_neg = ~r_quo + 1'b1;

    always_comb begin
        w_res.sample  = r_quo;
        w_res.clipped = 1'b0;
        if (!r_neg4) begin
            if (r_quo > cvr_pkg::MAG_POS_MAX) begin
                w_res.sample  = cvr_pkg::MAG_POS_MAX;
                w_res.clipped = 1'b1;
            end
        end else begin
            if (r_quo > cvr_pkg::MAG_NEG_MAX) begin
                w_res.sample  = cvr_pkg::MAG_NEG_MAX;
                w_res.clipped = 1'b1;
            end else begin
                w_res.sample = w_quo_neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[3]) begin
            r_res <= w_res;
        end
    end

    assign o_done = r_v[4];
    assign o_res  = r_res;

endmodule

FILE: design/convolution_reverb_wet_dry_top.sv
// Per-channel convolution reverb with wet/dry mix. Taps and sample history
// live in two memories of CHANNELS*TAPS words each. A tap-write item gives no
// output and leaves the input ready. A sample item pushes the sample into its
// channel's history and then runs the FIR one tap per cycle through the single
// multiply-accumulate unit: it reads every tap, drains the multiply and
// accumulate stages, runs the mix, divide and saturate pipeline, and loads the
// output register. The result item is presented in the same cycle as the input
// is ready again; a previous result item that is still waiting holds that load,
// and the input with it, until it is taken. The input side may accept the next
// item while a finished output still waits. After reset the block first clears
// both memories with the input side not ready; wet_percent writes are taken at
// any time.
// ---------------------------------------------------------------------------
// Convolution reverb, wet/dry mix, top level
// Sequencer, history heads, memories and the output register.
// ---------------------------------------------------------------------------
module convolution_reverb_wet_dry_top #(
    parameter int unsigned TAPS     = 1024,
    parameter int unsigned CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] channel, [10:1] tap_index, [26:11] value, [31:27] zero
    input  logic [cvr_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] kind
    input  logic                              i_s_axis_tuser,
    // Output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] out_channel, [16:1] out_sample, [23:17] zero
    output logic [cvr_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] clipped
    output logic                              o_m_axis_tuser,
    // Configuration: wet_percent
    input  logic                              i_cfg_we,
    input  logic [cvr_pkg::PCT_W-1:0]         i_cfg_wdata
);

    localparam int unsigned DEPTH  = CHANNELS * TAPS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned K_W    = $clog2(TAPS);
    localparam int unsigned ACC_W  = cvr_pkg::PROD_W + $clog2(TAPS);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_MIX   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [ADDR_W-1:0]               r_clr_addr;
    logic [K_W-1:0]                  r_head [cvr_pkg::CH_IDS];
    logic [cvr_pkg::PCT_W-1:0]       r_wet;
    logic [cvr_pkg::CH_W-1:0]        r_ch;
    logic [cvr_pkg::SAMPLE_W-1:0]    r_dry;
    logic [ADDR_W-1:0]               r_base;
    logic [K_W-1:0]                  r_k;
    logic [K_W-1:0]                  r_idx;
    logic                            r_out_valid;
    logic [cvr_pkg::CH_W-1:0]        r_out_ch;
    cvr_pkg::t_mix_res               r_out_res;

    logic                            w_kind;
    logic [cvr_pkg::CH_W-1:0]        w_ch;
    logic [cvr_pkg::TAP_IDX_W-1:0]   w_tix;
    logic [cvr_pkg::SAMPLE_W-1:0]    w_val;
    logic                            w_acc_in;
    logic                            w_ch_ok;
    logic                            w_tix_ok;
    logic [31:0]                     w_base32;
    logic [K_W-1:0]                  w_head_cur;
    logic [K_W-1:0]                  w_head_nxt;
    logic                            w_tap_wr;
    logic                            w_start;
    logic                            w_clearing;
    logic                            w_clr_last;
    logic                            w_k_last;
    logic                            w_out_free;
    logic                            w_load;
    logic                            w_mix_start;

    logic                            w_tap_we;
    logic [ADDR_W-1:0]               w_tap_waddr;
    logic [cvr_pkg::SAMPLE_W-1:0]    w_tap_wdata;
    logic                            w_hist_we;
    logic [ADDR_W-1:0]               w_hist_waddr;
    logic [cvr_pkg::SAMPLE_W-1:0]    w_hist_wdata;
    logic                            w_rd_en;
    logic [ADDR_W-1:0]               w_tap_raddr;
    logic [ADDR_W-1:0]               w_hist_raddr;
    logic [cvr_pkg::SAMPLE_W-1:0]    w_tap_rdata;
    logic [cvr_pkg::SAMPLE_W-1:0]    w_hist_rdata;

    cvr_pkg::t_mac_ctl               w_mac_ctl;
    logic signed [ACC_W-1:0]         w_acc;
    logic                            w_mac_empty;
    logic                            w_mix_done;
    cvr_pkg::t_mix_res               w_mix_res;

    // Unpack the input item
    assign w_kind = i_s_axis_tuser;
    assign w_ch   = i_s_axis_tdata[0];
    assign w_tix  = i_s_axis_tdata[10:1];
    assign w_val  = i_s_axis_tdata[26:11];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_acc_in        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ch_ok         = (32'(w_ch) < CHANNELS);
    assign w_tix_ok        = (32'(w_tix) < TAPS);
    assign w_base32        = w_ch ? TAPS : 32'd0;

    // Next history slot of the item's channel
    assign w_head_cur = r_head[w_ch];
    assign w_head_nxt = (w_head_cur == K_W'(TAPS - 1)) ? '0 : w_head_cur + 1'b1;

    assign w_tap_wr = w_acc_in && (w_kind == cvr_pkg::KIND_TAP) && w_ch_ok && w_tix_ok;
    assign w_start  = w_acc_in && (w_kind == cvr_pkg::KIND_SAMPLE) && w_ch_ok;

    assign w_clearing  = (r_state == ST_CLEAR);
    assign w_clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign w_k_last    = (r_k == K_W'(TAPS - 1));
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_load      = (r_state == ST_OUT) && w_out_free;
    assign w_mix_start = (r_state == ST_DRAIN) && w_mac_empty;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (w_k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_mac_empty) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (w_mix_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '{default: '0};
            r_wet       <= cvr_pkg::PCT_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_start) begin
                r_head[w_ch] <= w_head_nxt;
            end
            if (i_cfg_we) begin
                r_wet <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the sample context and walk taps and history
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_ch   <= w_ch;
            r_dry  <= w_val;
            r_base <= ADDR_W'(w_base32);
            r_k    <= '0;
            r_idx  <= w_head_nxt;
        end else if (r_state == ST_MAC) begin
            r_k   <= r_k + 1'b1;
            r_idx <= (r_idx == '0) ? K_W'(TAPS - 1) : r_idx - 1'b1;
        end
        if (w_load) begin
            r_out_ch  <= r_ch;
            r_out_res <= w_mix_res;
        end
    end

    // Memory ports: clearing sweep, tap writes, history pushes, FIR reads
    assign w_tap_we     = w_clearing || w_tap_wr;
    assign w_tap_waddr  = w_clearing ? r_clr_addr : ADDR_W'(w_base32 + 32'(w_tix));
    assign w_tap_wdata  = w_clearing ? '0 : w_val;
    assign w_hist_we    = w_clearing || w_start;
    assign w_hist_waddr = w_clearing ? r_clr_addr : ADDR_W'(w_base32 + 32'(w_head_nxt));
    assign w_hist_wdata = w_clearing ? '0 : w_val;
    assign w_rd_en      = (r_state == ST_MAC);
    assign w_tap_raddr  = r_base + ADDR_W'(r_k);
    assign w_hist_raddr = r_base + ADDR_W'(r_idx);

    cvr_ram #(
        .WIDTH (cvr_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tap_we),
        .i_waddr (w_tap_waddr),
        .i_wdata (w_tap_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_tap_raddr),
        .o_rdata (w_tap_rdata)
    );

    cvr_ram #(
        .WIDTH (cvr_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata)
    );

    // Multiply-accumulate over the taps
    assign w_mac_ctl.clr   = w_start;
    assign w_mac_ctl.issue = w_rd_en;

    cvr_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_tap   (w_tap_rdata),
        .i_hist  (w_hist_rdata),
        .o_acc   (w_acc),
        .o_empty (w_mac_empty)
    );

    // Wet/dry mix, scale and saturate
    cvr_mix #(
        .ACC_W (ACC_W)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mix_start),
        .i_acc   (w_acc),
        .i_dry   (r_dry),
        .i_wet   (r_wet),
        .o_done  (w_mix_done),
        .o_res   (w_mix_res)
    );

    // Output item
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_res.sample, r_out_ch};
    assign o_m_axis_tuser  = r_out_res.clipped;

endmodule

FILE: design/cvr_checker.sv
// ---------------------------------------------------------------------------
// Convolution reverb port checker
// Watches the top level's ports and flags output and sequencing slips.
// ---------------------------------------------------------------------------
`include "convolution_reverb_wet_dry_top_defines.svh"

module cvr_checker #(
    parameter int unsigned CHANNELS = 2
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           i_s_tready,
    input logic [cvr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input logic                           i_s_tuser,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [cvr_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input logic                           i_m_tuser
);

    // Hold a stalled output item
    `CVR_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "output item dropped while stalled")
    `CVR_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata) && $stable(i_m_tuser), "stalled output item changed")

    // A clipped result sits at one of the two limits
    `CVR_ASSERT_NOW(a_clip_at_limit, i_clk, i_rst_n, i_m_tvalid && i_m_tuser, (i_m_tdata[16:1] == 16'h7FFF) || (i_m_tdata[16:1] == 16'h8000), "clipped flag on an unsaturated sample")

    // A sample item on a valid channel starts the filter run
    `CVR_ASSERT_NEXT(a_busy_after_sample, i_clk, i_rst_n, i_s_tvalid && i_s_tready && (i_s_tuser == cvr_pkg::KIND_SAMPLE) && (32'(i_s_tdata[0]) < CHANNELS), !i_s_tready, "input ready right after a sample item")

    // A new output item only comes out of a filter run
    `CVR_ASSERT_NOW(a_out_from_run, i_clk, i_rst_n, $rose(i_m_tvalid), !$past(i_s_tready), "output item appeared while the input side was idle")

endmodule

bind convolution_reverb_wet_dry_top cvr_checker #(
    .CHANNELS (CHANNELS)
) u_cvr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_s_tdata  (i_s_axis_tdata),
    .i_s_tuser  (i_s_axis_tuser),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);
